>>> rtl/assert_macros.svh
// Assertion macros shared by the profiler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/swcp_pkg.sv
// Shared constants, codes and control types of the cycle profiler.
package swcp_pkg;

	localparam int unsigned WINDOW_DEPTH_DEF = 256;

	localparam int unsigned TICK_W    = 24;
	localparam int unsigned SUM_W     = 32;
	localparam int unsigned CNT_OUT_W = 9;
	localparam int unsigned CPU_W     = 7;
	localparam int unsigned JIT_W     = 31;
	localparam int unsigned DVD_W     = 39;
	localparam int unsigned ITER_W    = 5;

	typedef enum logic {
		OP_CPU = 1'b0,
		OP_JIT = 1'b1
	} div_op_t;

	typedef struct packed {
		logic    capture;
		logic    update;
		logic    div_start;
		div_op_t div_op;
		logic    cpu_take;
		logic    out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
	} dp_sts_t;

endpackage

>>> rtl/swcp_div.sv
// Shared restoring divider that produces one quotient bit per cycle.
`include "assert_macros.svh"

module swcp_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [swcp_pkg::ITER_W-1:0]          iters,
	input  logic [swcp_pkg::SUM_W-1:0]           rem_init,
	input  logic [swcp_pkg::JIT_W-1:0]           dsr_init,
	input  logic [swcp_pkg::SUM_W-1:0]           divisor,
	output logic                                 done,
	output logic [swcp_pkg::JIT_W-1:0]           quotient
);

	logic                           busy_q;
	logic                           done_q;
	logic [swcp_pkg::ITER_W-1:0]    cnt_q;
	logic [swcp_pkg::SUM_W-1:0]     rem_q;
	logic [swcp_pkg::JIT_W-1:0]     dsr_q;
	logic [swcp_pkg::JIT_W-1:0]     quo_q;
	logic [swcp_pkg::SUM_W-1:0]     divisor_q;

	logic [swcp_pkg::SUM_W:0]       shifted;
	logic [swcp_pkg::SUM_W:0]       trial;
	logic                           ge;

	// The partial remainder stays below the divisor, so the shifted value fits in one extra bit.
	assign shifted = {rem_q, dsr_q[swcp_pkg::JIT_W-1]};
	assign ge      = shifted >= {1'b0, divisor_q};
	assign trial   = shifted - {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == swcp_pkg::ITER_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= rem_init;
			dsr_q     <= dsr_init;
			quo_q     <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? trial[swcp_pkg::SUM_W-1:0] : shifted[swcp_pkg::SUM_W-1:0];
			dsr_q <= {dsr_q[swcp_pkg::JIT_W-2:0], 1'b0};
			quo_q <= {quo_q[swcp_pkg::JIT_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	`ASSERT_RST(a_rem_below_divisor, clk, arst_n, busy_q |-> (rem_q < divisor_q), "remainder not below divisor")
	`ASSERT_RST(a_last_step_done, clk, arst_n, (busy_q && !start && cnt_q == swcp_pkg::ITER_W'(1)) |=> (done_q && !busy_q), "divider did not finish after last step")

endmodule

>>> rtl/swcp_dp.sv
// Datapath: input capture, sample rings, window statistics, divider feed and output registers.
`include "assert_macros.svh"

module swcp_dp #(
	parameter int unsigned WINDOW_DEPTH = swcp_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 mode,
	input  logic [swcp_pkg::TICK_W-1:0]          period,
	input  logic [swcp_pkg::TICK_W-1:0]          busy_req,
	input  logic                                 cfg_valid,
	input  logic [swcp_pkg::TICK_W-1:0]          cfg_data,
	input  swcp_pkg::dp_cmd_t                    cmd,
	output swcp_pkg::dp_sts_t                    sts,
	output logic                                 tick_ignored,
	output logic [swcp_pkg::CNT_OUT_W-1:0]       held_samples,
	output logic [swcp_pkg::SUM_W-1:0]           period_sum,
	output logic [swcp_pkg::SUM_W-1:0]           busy_sum,
	output logic [swcp_pkg::TICK_W-1:0]          max_period,
	output logic [swcp_pkg::TICK_W-1:0]          min_period,
	output logic [swcp_pkg::SUM_W-1:0]           overrun_events,
	output logic [swcp_pkg::CPU_W-1:0]           cpu_percent,
	output logic [swcp_pkg::JIT_W-1:0]           jitter_percent
);

	localparam int unsigned CNT_W  = $clog2(WINDOW_DEPTH + 1);
	localparam int unsigned ADDR_W = $clog2(WINDOW_DEPTH);
	localparam int unsigned MUL_W  = swcp_pkg::TICK_W + 4;

	// Sample rings, no reset: entries past the fill count read as zero.
	logic [swcp_pkg::TICK_W-1:0] pring [WINDOW_DEPTH];
	logic [swcp_pkg::TICK_W-1:0] bring [WINDOW_DEPTH];
	logic [swcp_pkg::TICK_W-1:0] rd_p_q;
	logic [swcp_pkg::TICK_W-1:0] rd_b_q;

	// Captured item.
	logic                        mode_q;
	logic                        ign_q;
	logic                        ovr_q;
	logic [swcp_pkg::TICK_W-1:0] per_q;
	logic [swcp_pkg::TICK_W-1:0] bsy_q;

	// Statistics.
	logic [swcp_pkg::TICK_W-1:0] nom_q;
	logic [ADDR_W-1:0]           slot_q;
	logic [CNT_W-1:0]            count_q;
	logic [swcp_pkg::SUM_W-1:0]  ptot_q;
	logic [swcp_pkg::SUM_W-1:0]  btot_q;
	logic [swcp_pkg::TICK_W-1:0] pmax_q;
	logic [swcp_pkg::TICK_W-1:0] pmin_q;
	logic [swcp_pkg::SUM_W-1:0]  ovr_tot_q;
	logic [swcp_pkg::CPU_W-1:0]  cpu_q;

	logic                        full;
	logic                        first;
	logic                        record;
	logic [swcp_pkg::TICK_W-1:0] old_p;
	logic [swcp_pkg::TICK_W-1:0] old_b;
	logic [MUL_W-1:0]            p10;
	logic [MUL_W-1:0]            n11;
	logic [MUL_W-1:0]            px;
	logic [MUL_W-1:0]            nx;

	logic [swcp_pkg::DVD_W-1:0]  bx;
	logic [swcp_pkg::DVD_W-1:0]  cpu_dvd;
	logic [swcp_pkg::JIT_W-1:0]  dx;
	logic [swcp_pkg::JIT_W-1:0]  jit_dvd;
	logic                        jit_ok;

	logic [swcp_pkg::ITER_W-1:0] div_iters;
	logic [swcp_pkg::SUM_W-1:0]  div_rem;
	logic [swcp_pkg::JIT_W-1:0]  div_dsr;
	logic [swcp_pkg::SUM_W-1:0]  div_divisor;
	logic [swcp_pkg::JIT_W-1:0]  quotient;
	logic                        div_done;

	// Overrun test: period > nom + floor(nom / 10) holds exactly when 10 * period > 11 * nom.
	assign px  = MUL_W'(period);
	assign nx  = MUL_W'(nom_q);
	assign p10 = (px << 3) + (px << 1);
	assign n11 = (nx << 3) + (nx << 1) + nx;

	assign full   = count_q == CNT_W'(WINDOW_DEPTH);
	assign first  = count_q == '0;
	assign record = !mode_q && !ign_q;
	assign old_p  = full ? rd_p_q : '0;
	assign old_b  = full ? rd_b_q : '0;

	always_ff @(posedge clk) begin
		if (cmd.update && record) begin
			pring[slot_q] <= per_q;
			bring[slot_q] <= bsy_q;
		end
		rd_p_q <= pring[slot_q];
		rd_b_q <= bring[slot_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode;
			ign_q  <= !mode && (period == '0);
			ovr_q  <= p10 > n11;
			per_q  <= period;
			bsy_q  <= (busy_req > period) ? period : busy_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nom_q <= swcp_pkg::TICK_W'(1);
		end else if (cfg_valid) begin
			nom_q <= (cfg_data == '0) ? swcp_pkg::TICK_W'(1) : cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q    <= '0;
			count_q   <= '0;
			ptot_q    <= '0;
			btot_q    <= '0;
			pmax_q    <= '0;
			pmin_q    <= '0;
			ovr_tot_q <= '0;
		end else if (cmd.update) begin
			if (mode_q) begin
				slot_q    <= '0;
				count_q   <= '0;
				ptot_q    <= '0;
				btot_q    <= '0;
				pmax_q    <= '0;
				pmin_q    <= '0;
				ovr_tot_q <= '0;
			end else if (!ign_q) begin
				ptot_q <= ptot_q - swcp_pkg::SUM_W'(old_p) + swcp_pkg::SUM_W'(per_q);
				btot_q <= btot_q - swcp_pkg::SUM_W'(old_b) + swcp_pkg::SUM_W'(bsy_q);
				if (!full) begin
					count_q <= count_q + 1'b1;
				end
				if (first || per_q > pmax_q) begin
					pmax_q <= per_q;
				end
				if (first || per_q < pmin_q) begin
					pmin_q <= per_q;
				end
				if (ovr_q) begin
					ovr_tot_q <= ovr_tot_q + 1'b1;
				end
				slot_q <= (slot_q == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : slot_q + 1'b1;
			end
		end
	end

	// Load: busy sum times 100 has a quotient below 128, so only seven steps are needed.
	assign bx      = swcp_pkg::DVD_W'(btot_q);
	assign cpu_dvd = (bx << 6) + (bx << 5) + (bx << 2);
	assign jit_ok  = (count_q >= CNT_W'(2)) && (pmax_q >= pmin_q);
	assign dx      = jit_ok ? swcp_pkg::JIT_W'(pmax_q - pmin_q) : '0;
	assign jit_dvd = (dx << 6) + (dx << 5) + (dx << 2);

	always_comb begin
		unique case (cmd.div_op)
			swcp_pkg::OP_CPU: begin
				div_iters   = swcp_pkg::ITER_W'(swcp_pkg::CPU_W);
				div_rem     = cpu_dvd[swcp_pkg::DVD_W-1:swcp_pkg::CPU_W];
				div_dsr     = {cpu_dvd[swcp_pkg::CPU_W-1:0],
					{(swcp_pkg::JIT_W - swcp_pkg::CPU_W){1'b0}}};
				// An empty window also has a zero busy sum, so a divisor of one yields zero.
				div_divisor = (ptot_q == '0) ? swcp_pkg::SUM_W'(1) : ptot_q;
			end
			swcp_pkg::OP_JIT: begin
				div_iters   = swcp_pkg::ITER_W'(swcp_pkg::JIT_W);
				div_rem     = '0;
				div_dsr     = jit_dvd;
				div_divisor = swcp_pkg::SUM_W'(nom_q);
			end
			default: begin
				div_iters   = '0;
				div_rem     = '0;
				div_dsr     = '0;
				div_divisor = swcp_pkg::SUM_W'(1);
			end
		endcase
	end

	swcp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.iters    (div_iters),
		.rem_init (div_rem),
		.dsr_init (div_dsr),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (quotient)
	);

	assign sts.div_done = div_done;

	always_ff @(posedge clk) begin
		if (cmd.cpu_take) begin
			cpu_q <= quotient[swcp_pkg::CPU_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			tick_ignored   <= ign_q;
			held_samples   <= swcp_pkg::CNT_OUT_W'(count_q);
			period_sum     <= ptot_q;
			busy_sum       <= btot_q;
			max_period     <= pmax_q;
			min_period     <= pmin_q;
			overrun_events <= ovr_tot_q;
			cpu_percent    <= cpu_q;
			jitter_percent <= quotient;
		end
	end

	`ASSERT_RST(a_busy_within_period, clk, arst_n, btot_q <= ptot_q, "busy sum exceeds period sum")
	`ASSERT_RST(a_empty_sums_zero, clk, arst_n, (count_q == '0) |-> (ptot_q == '0 && btot_q == '0 && pmax_q == '0), "empty window holds nonzero statistics")

endmodule

>>> rtl/swcp_ctrl.sv
// Sequencer that steps each item through update, two divisions and the output register.
`include "assert_macros.svh"

module swcp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output swcp_pkg::dp_cmd_t cmd,
	input  swcp_pkg::dp_sts_t sts
);

	typedef enum logic [6:0] {
		ST_IDLE      = 7'b0000001,
		ST_UPDATE    = 7'b0000010,
		ST_CPU_START = 7'b0000100,
		ST_CPU_WAIT  = 7'b0001000,
		ST_JIT_START = 7'b0010000,
		ST_JIT_WAIT  = 7'b0100000,
		ST_DONE      = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	// The output register is free when empty or when its beat leaves this cycle.
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.div_op     = swcp_pkg::OP_CPU;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = ST_CPU_START;
			end
			ST_CPU_START: begin
				cmd.div_start = 1'b1;
				state_d       = ST_CPU_WAIT;
			end
			ST_CPU_WAIT: begin
				if (sts.div_done) begin
					cmd.cpu_take = 1'b1;
					state_d      = ST_JIT_START;
				end
			end
			ST_JIT_START: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = swcp_pkg::OP_JIT;
				state_d       = ST_JIT_WAIT;
			end
			ST_JIT_WAIT: begin
				cmd.div_op = swcp_pkg::OP_JIT;
				if (sts.div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = out_valid_q;

	`ASSERT_RST(a_done_loads_output, clk, arst_n, (state_q == ST_DONE && out_free) |=> (out_valid_q && state_q == ST_IDLE), "finished item not moved to output")
	`ASSERT_RST(a_accept_starts_update, clk, arst_n, (in_valid && !in_stall) |=> (state_q == ST_UPDATE), "accepted item did not reach update")

endmodule

>>> rtl/sliding_window_cycle_profiler_core.sv
// Top level of the sliding-window cycle profiler: sequencer plus datapath.
//
// Input channel (in_valid / in_stall): one beat carries mode, period and busy_req.
// Mode 0 records one tick (period zero is reported as ignored), mode 1 clears the
// window and all statistics. Output channel (out_valid / out_stall): one beat per
// input beat, holding the statistics snapshot after that item.
// The configuration channel (cfg_valid / cfg_ready / cfg_data) writes the nominal
// period; a zero write is stored as one. cfg_ready is always high; write it only
// while no item is in flight.
// From input acceptance to out_valid the item passes capture and update, then a
// bit-serial divider runs 7 steps for the load percentage and 31 steps for jitter.
// One item is in flight at a time; a new item is accepted the cycle after the
// previous result enters the output register, so no new item is taken while one
// is still being worked on. If the receiver stalls, the result holds and
// a following item still runs, waiting at the end until the output register frees.
// Reset clears the statistics and sets the nominal period to one; the sample rings
// need no clearing pass because entries past the fill count read as zero.
module sliding_window_cycle_profiler_core #(
	parameter int unsigned WINDOW_DEPTH = swcp_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 mode,
	input  logic [swcp_pkg::TICK_W-1:0]          period,
	input  logic [swcp_pkg::TICK_W-1:0]          busy_req,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [swcp_pkg::TICK_W-1:0]          cfg_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 tick_ignored,
	output logic [swcp_pkg::CNT_OUT_W-1:0]       held_samples,
	output logic [swcp_pkg::SUM_W-1:0]           period_sum,
	output logic [swcp_pkg::SUM_W-1:0]           busy_sum,
	output logic [swcp_pkg::TICK_W-1:0]          max_period,
	output logic [swcp_pkg::TICK_W-1:0]          min_period,
	output logic [swcp_pkg::SUM_W-1:0]           overrun_events,
	output logic [swcp_pkg::CPU_W-1:0]           cpu_percent,
	output logic [swcp_pkg::JIT_W-1:0]           jitter_percent
);

	swcp_pkg::dp_cmd_t cmd;
	swcp_pkg::dp_sts_t sts;

	assign cfg_ready = 1'b1;

	swcp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	swcp_dp #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.mode           (mode),
		.period         (period),
		.busy_req       (busy_req),
		.cfg_valid      (cfg_valid),
		.cfg_data       (cfg_data),
		.cmd            (cmd),
		.sts            (sts),
		.tick_ignored   (tick_ignored),
		.held_samples   (held_samples),
		.period_sum     (period_sum),
		.busy_sum       (busy_sum),
		.max_period     (max_period),
		.min_period     (min_period),
		.overrun_events (overrun_events),
		.cpu_percent    (cpu_percent),
		.jitter_percent (jitter_percent)
	);

endmodule

>>> bench/swcp_snapshot_checker.sv
// Snapshot checker for the cycle profiler: tracks the statistics and checks every output beat.
module swcp_snapshot_checker #(
	parameter int unsigned DEPTH = swcp_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic                           mode,
	input  logic [swcp_pkg::TICK_W-1:0]    period,
	input  logic [swcp_pkg::TICK_W-1:0]    busy_req,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [swcp_pkg::TICK_W-1:0]    cfg_data,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic                           tick_ignored,
	input  logic [swcp_pkg::CNT_OUT_W-1:0] held_samples,
	input  logic [swcp_pkg::SUM_W-1:0]     period_sum,
	input  logic [swcp_pkg::SUM_W-1:0]     busy_sum,
	input  logic [swcp_pkg::TICK_W-1:0]    max_period,
	input  logic [swcp_pkg::TICK_W-1:0]    min_period,
	input  logic [swcp_pkg::SUM_W-1:0]     overrun_events,
	input  logic [swcp_pkg::CPU_W-1:0]     cpu_percent,
	input  logic [swcp_pkg::JIT_W-1:0]     jitter_percent,
	output int unsigned                    fail_count,
	output int unsigned                    outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic                           ignored;
		logic [swcp_pkg::CNT_OUT_W-1:0] count;
		logic [swcp_pkg::SUM_W-1:0]     psum;
		logic [swcp_pkg::SUM_W-1:0]     bsum;
		logic [swcp_pkg::TICK_W-1:0]    pmax;
		logic [swcp_pkg::TICK_W-1:0]    pmin;
		logic [swcp_pkg::SUM_W-1:0]     overruns;
		logic [swcp_pkg::CPU_W-1:0]     cpu;
		logic [swcp_pkg::JIT_W-1:0]     jitter;
	} snapshot_t;

	logic [swcp_pkg::TICK_W-1:0] period_hist [DEPTH];
	logic [swcp_pkg::TICK_W-1:0] busy_hist [DEPTH];
	int unsigned                 slot_ptr;
	int unsigned                 held;
	logic [swcp_pkg::SUM_W-1:0]  period_acc;
	logic [swcp_pkg::SUM_W-1:0]  busy_acc;
	logic [swcp_pkg::SUM_W-1:0]  overrun_acc;
	logic [swcp_pkg::TICK_W-1:0] longest;
	logic [swcp_pkg::TICK_W-1:0] shortest;
	logic [swcp_pkg::TICK_W-1:0] nominal;
	snapshot_t                   expected_snapshots [$];
	snapshot_t                   fresh;
	snapshot_t                   want;
	bit                          all_ok;

	function automatic void clear_window();
		for (int i = 0; i < DEPTH; i++) begin
			period_hist[i] = '0;
			busy_hist[i] = '0;
		end
		slot_ptr = 0;
		held = 0;
		period_acc = '0;
		busy_acc = '0;
		overrun_acc = '0;
		longest = '0;
		shortest = '0;
	endfunction

	// Applies one input beat to the tracked statistics and returns the snapshot it yields.
	function automatic snapshot_t advance_profile(input logic clear_req,
			input logic [swcp_pkg::TICK_W-1:0] p, input logic [swcp_pkg::TICK_W-1:0] b);
		snapshot_t                   snap;
		logic [swcp_pkg::TICK_W-1:0] b_clamped;
		longint unsigned             ratio;
		int unsigned                 limit;
		snap = '0;
		if (clear_req) begin
			clear_window();
		end else if (p == '0) begin
			snap.ignored = 1'b1;
		end else begin
			b_clamped = (b > p) ? p : b;
			period_acc = period_acc - swcp_pkg::SUM_W'(period_hist[slot_ptr])
				+ swcp_pkg::SUM_W'(p);
			busy_acc = busy_acc - swcp_pkg::SUM_W'(busy_hist[slot_ptr])
				+ swcp_pkg::SUM_W'(b_clamped);
			period_hist[slot_ptr] = p;
			busy_hist[slot_ptr] = b_clamped;
			if (held < DEPTH)
				held++;
			if (held == 1 || p > longest)
				longest = p;
			if (held == 1 || p < shortest)
				shortest = p;
			// The threshold can exceed 24 bits, so it is formed at full integer width.
			limit = int'(nominal) + int'(nominal) / 10;
			if (int'(p) > limit)
				overrun_acc = overrun_acc + 1'b1;
			slot_ptr = (slot_ptr == DEPTH - 1) ? 0 : slot_ptr + 1;
		end
		snap.count = swcp_pkg::CNT_OUT_W'(held);
		snap.psum = period_acc;
		snap.bsum = busy_acc;
		snap.pmax = longest;
		snap.pmin = shortest;
		snap.overruns = overrun_acc;
		if (period_acc != '0) begin
			ratio = (longint'(busy_acc) * 100) / longint'(period_acc);
			snap.cpu = ratio[swcp_pkg::CPU_W-1:0];
		end
		if (held >= 2) begin
			ratio = (longint'(longest) - longint'(shortest)) * 100 / longint'(nominal);
			snap.jitter = ratio[swcp_pkg::JIT_W-1:0];
		end
		return snap;
	endfunction

	function automatic bit field_ok(input string name, input logic [63:0] exp_val,
			input logic [63:0] act_val);
		if (exp_val === act_val)
			return 1'b1;
		$display("%0d ns: %s mismatch, expected %0d, actual %0d", $time, name,
			exp_val, act_val);
		return 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_window();
			nominal = swcp_pkg::TICK_W'(1);
			expected_snapshots.delete();
			fail_count = 0;
			outstanding = 0;
		end else begin
			// The oldest result leaves before a new item's snapshot is queued.
			if (out_valid && !out_stall) begin
				if (expected_snapshots.size() == 0) begin
					$display("%0d ns: output beat with nothing expected, actual held_samples %0d",
						$time, held_samples);
					fail_count++;
				end else begin
					want = expected_snapshots.pop_front();
					all_ok = field_ok("tick_ignored", want.ignored, tick_ignored)
						& field_ok("held_samples", want.count, held_samples)
						& field_ok("period_sum", want.psum, period_sum)
						& field_ok("busy_sum", want.bsum, busy_sum)
						& field_ok("max_period", want.pmax, max_period)
						& field_ok("min_period", want.pmin, min_period)
						& field_ok("overrun_events", want.overruns, overrun_events)
						& field_ok("cpu_percent", want.cpu, cpu_percent)
						& field_ok("jitter_percent", want.jitter, jitter_percent);
					if (!all_ok)
						fail_count++;
				end
			end
			if (in_valid && !in_stall) begin
				fresh = advance_profile(mode, period, busy_req);
				expected_snapshots.push_back(fresh);
			end
			if (cfg_valid && cfg_ready)
				nominal = (cfg_data == '0) ? swcp_pkg::TICK_W'(1) : cfg_data;
			outstanding = expected_snapshots.size();
		end
	end

endmodule

>>> bench/tb.sv
// Testbench top for the cycle profiler: clock, reset, stimulus, watchdog and verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic                        MODE_RECORD    = 1'b0;
	localparam logic                        MODE_CLEAR     = 1'b1;
	localparam logic [swcp_pkg::TICK_W-1:0] TICK_MAX       = '1;
	localparam int unsigned                 WATCHDOG_LIMIT = 4000;
	localparam int unsigned                 TAIL_CYCLES    = 60;
	localparam int unsigned                 PHASES         = 5;
	localparam int unsigned                 PHASE_ITEMS    = 207;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_stall;
	logic                           mode;
	logic [swcp_pkg::TICK_W-1:0]    period;
	logic [swcp_pkg::TICK_W-1:0]    busy_req;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [swcp_pkg::TICK_W-1:0]    cfg_data;
	logic                           out_valid;
	logic                           out_stall;
	logic                           tick_ignored;
	logic [swcp_pkg::CNT_OUT_W-1:0] held_samples;
	logic [swcp_pkg::SUM_W-1:0]     period_sum;
	logic [swcp_pkg::SUM_W-1:0]     busy_sum;
	logic [swcp_pkg::TICK_W-1:0]    max_period;
	logic [swcp_pkg::TICK_W-1:0]    min_period;
	logic [swcp_pkg::SUM_W-1:0]     overrun_events;
	logic [swcp_pkg::CPU_W-1:0]     cpu_percent;
	logic [swcp_pkg::JIT_W-1:0]     jitter_percent;
	int unsigned                    fail_count;
	int unsigned                    outstanding;
	int unsigned                    quiet_cycles = 0;
	int unsigned                    nominal_now = 1;
	bit                             quiet_sender = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	sliding_window_cycle_profiler_core DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .period(period), .busy_req(busy_req),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_stall(out_stall),
		.tick_ignored(tick_ignored), .held_samples(held_samples),
		.period_sum(period_sum), .busy_sum(busy_sum),
		.max_period(max_period), .min_period(min_period),
		.overrun_events(overrun_events), .cpu_percent(cpu_percent),
		.jitter_percent(jitter_percent)
	);

	swcp_snapshot_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .period(period), .busy_req(busy_req),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_stall(out_stall),
		.tick_ignored(tick_ignored), .held_samples(held_samples),
		.period_sum(period_sum), .busy_sum(busy_sum),
		.max_period(max_period), .min_period(min_period),
		.overrun_events(overrun_events), .cpu_percent(cpu_percent),
		.jitter_percent(jitter_percent),
		.fail_count(fail_count), .outstanding(outstanding)
	);

	// Presents one beat after a random gap and holds it until the block takes it.
	// Valid stays high afterwards; the next beat or a drain decides what follows.
	task automatic send_beat(input logic m, input logic [swcp_pkg::TICK_W-1:0] p,
			input logic [swcp_pkg::TICK_W-1:0] b);
		int unsigned roll;
		int unsigned gap;
		roll = $urandom_range(99);
		if (quiet_sender || roll < 40)
			gap = 0;
		else if (roll < 80)
			gap = $urandom_range(6, 1);
		else if (roll < 95)
			gap = $urandom_range(60, 7);
		else
			gap = $urandom_range(200, 61);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		period <= p;
		busy_req <= b;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic write_nominal(input logic [swcp_pkg::TICK_W-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		nominal_now = (v == '0) ? 1 : int'(v);
	endtask

	// Receiver: free stretches and stall stretches of random length, none of them empty.
	initial begin
		int unsigned roll;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			roll = $urandom_range(99);
			if (roll < 70)
				repeat ($urandom_range(40, 1)) @(negedge clk);
			else if (roll < 90)
				repeat ($urandom_range(120, 41)) @(negedge clk);
			else
				repeat ($urandom_range(800, 300)) @(negedge clk);
			out_stall <= 1'b1;
			roll = $urandom_range(99);
			if (roll < 70)
				repeat ($urandom_range(4, 1)) @(negedge clk);
			else if (roll < 93)
				repeat ($urandom_range(45, 5)) @(negedge clk);
			else
				repeat ($urandom_range(200, 100)) @(negedge clk);
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int unsigned                 counted;
		int unsigned                 clear_odds;
		int unsigned                 roll;
		int unsigned                 lo;
		int unsigned                 hi;
		logic                        m;
		logic [swcp_pkg::TICK_W-1:0] p;
		logic [swcp_pkg::TICK_W-1:0] b;
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_RECORD;
		period = '0;
		busy_req = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// Directed part, first with the nominal period left at its reset value.
		send_beat(MODE_RECORD, '0, 24'd5);
		send_beat(MODE_CLEAR, TICK_MAX, TICK_MAX);
		send_beat(MODE_RECORD, 24'd1, '0);
		send_beat(MODE_RECORD, TICK_MAX, TICK_MAX);
		send_beat(MODE_RECORD, 24'd2, TICK_MAX);
		send_beat(MODE_RECORD, '0, TICK_MAX);
		send_beat(MODE_RECORD, 24'hAAAAAA, 24'h555555);
		send_beat(MODE_RECORD, 24'h555555, 24'hAAAAAA);
		send_beat(MODE_CLEAR, '0, '0);
		send_beat(MODE_RECORD, 24'd5, 24'd5);
		drain();
		// Exactly 110 percent is not an overrun; one tick more is.
		write_nominal(24'd1000);
		send_beat(MODE_RECORD, 24'd1100, 24'd550);
		send_beat(MODE_RECORD, 24'd1101, 24'd1101);
		send_beat(MODE_RECORD, 24'd900, '0);
		drain();
		write_nominal('0);
		send_beat(MODE_RECORD, 24'd2, 24'd1);
		drain();
		// With the largest nominal the overrun threshold no longer fits in 24 bits.
		write_nominal(TICK_MAX);
		send_beat(MODE_RECORD, TICK_MAX, 24'd1);
		send_beat(MODE_RECORD, 24'd1, 24'd1);

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			unique case (ph)
				0: write_nominal(24'($urandom_range(5000, 100)));
				1: write_nominal('0);
				2: write_nominal(TICK_MAX);
				3: write_nominal(24'($urandom_range(TICK_MAX, 1)));
				default: write_nominal(24'($urandom_range(300, 2)));
			endcase
			quiet_sender = (ph == 2);
			// Clears are rare so the window fills and wraps; one phase clears often.
			clear_odds = (ph == 3) ? 12 : 500;
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				m = ($urandom_range(clear_odds - 1) == 0) ? MODE_CLEAR : MODE_RECORD;
				roll = $urandom_range(99);
				if (roll < 5) begin
					p = '0;
				end else if (roll < 40) begin
					lo = nominal_now - nominal_now / 5;
					hi = nominal_now + (nominal_now * 3) / 10;
					if (lo == 0)
						lo = 1;
					if (hi > TICK_MAX)
						hi = TICK_MAX;
					if ($urandom_range(3) == 0)
						hi = nominal_now + nominal_now / 10 + $urandom_range(1);
					else
						hi = $urandom_range(hi, lo);
					p = (hi > TICK_MAX) ? TICK_MAX : swcp_pkg::TICK_W'(hi);
				end else if (roll < 70) begin
					p = swcp_pkg::TICK_W'($urandom_range(TICK_MAX, 1));
				end else if (roll < 85) begin
					p = swcp_pkg::TICK_W'($urandom_range(255, 1));
				end else begin
					p = swcp_pkg::TICK_W'($urandom() >> $urandom_range(31, 8));
				end
				roll = $urandom_range(9);
				if (roll < 4)
					b = swcp_pkg::TICK_W'($urandom_range(p, 0));
				else if (roll < 6)
					b = swcp_pkg::TICK_W'($urandom_range(TICK_MAX, 0));
				else if (roll == 6)
					b = p;
				else if (roll == 7)
					b = '0;
				else if (roll == 8)
					b = (p == TICK_MAX) ? TICK_MAX : p + 1'b1;
				else
					b = swcp_pkg::TICK_W'($urandom_range(p, p - p / 8));
				send_beat(m, p, b);
				if (m == MODE_CLEAR || p != '0)
					counted++;
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
